>>> rtl/core/gdfs_pkg.sv
`default_nettype none
package gdfs_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int CNT_W      = ADDR_W + 1;
    localparam int DIM_W      = 7;
    localparam int POS_W      = DIM_W + 1;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;

    localparam logic [2:0] K_FREE  = 3'd0;
    localparam logic [2:0] K_WALL  = 3'd1;
    localparam logic [2:0] K_GOAL  = 3'd2;
    localparam logic [2:0] K_SEEN  = 3'd3;
    localparam logic [2:0] K_ROUTE = 3'd4;
    localparam logic [2:0] K_DEAD  = 3'd5;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic [1:0]       head;
        logic [2:0]       tried;
    } frame_t;

    localparam int FRAME_W = $bits(frame_t);

    // heading order: right, down, left, up
    function automatic logic [POS_W-1:0] step_row(input logic [1:0] d);
        logic [POS_W-1:0] s;
        begin
            case (d)
                2'd1:    s = POS_W'(1);
                2'd3:    s = {POS_W{1'b1}};
                default: s = '0;
            endcase
            return s;
        end
    endfunction

    function automatic logic [POS_W-1:0] step_col(input logic [1:0] d);
        logic [POS_W-1:0] s;
        begin
            case (d)
                2'd0:    s = POS_W'(1);
                2'd2:    s = {POS_W{1'b1}};
                default: s = '0;
            endcase
            return s;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/gdfs_ram.sv
`default_nettype none
module gdfs_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/gdfs_ctrl.sv
`default_nettype none
module gdfs_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  cmd,
    input  wire logic [gdfs_pkg::ROW_W-1:0]  row,
    input  wire logic [gdfs_pkg::COL_W-1:0]  col,
    input  wire logic [1:0]                  cell_kind,
    input  wire logic [gdfs_pkg::DIM_W-1:0]  used_rows,
    input  wire logic [gdfs_pkg::DIM_W-1:0]  used_cols,
    output logic                             grid_we,
    output logic [gdfs_pkg::ADDR_W-1:0]      grid_waddr,
    output logic [2:0]                       grid_wdata,
    output logic [gdfs_pkg::ADDR_W-1:0]      grid_raddr,
    input  wire logic [2:0]                  grid_rdata,
    output logic                             snap_we,
    output logic [gdfs_pkg::ADDR_W-1:0]      snap_waddr,
    output logic [2:0]                       snap_wdata,
    output logic [gdfs_pkg::ADDR_W-1:0]      snap_raddr,
    input  wire logic [2:0]                  snap_rdata,
    output logic                             stk_we,
    output logic [gdfs_pkg::ADDR_W-1:0]      stk_waddr,
    output gdfs_pkg::frame_t                 stk_wdata,
    output logic [gdfs_pkg::ADDR_W-1:0]      stk_raddr,
    input  gdfs_pkg::frame_t                 stk_rdata,
    output logic                             done,
    output logic                             goal_found,
    output logic [1:0]                       explore_mark,
    output logic [2:0]                       final_mark
);
    import gdfs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_CLR  = 7'b0000100,
        S_WALK = 7'b0001000,
        S_CHK  = 7'b0010000,
        S_POP  = 7'b0100000,
        S_COPY = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [CNT_W-1:0]  depth_reg, depth_next;
    frame_t            top_reg, top_next;
    logic [ROW_W-1:0]  nb_r_reg, nb_r_next;
    logic [COL_W-1:0]  nb_c_reg, nb_c_next;
    logic [1:0]        nb_head_reg, nb_head_next;
    logic              route_reg, route_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_exp_reg, out_exp_next;
    logic [2:0]        out_fin_reg, out_fin_next;

    logic              accept;
    logic [1:0]        dir;
    logic [POS_W-1:0]  nr, nc;
    logic              in_bounds;
    logic              can_enter;
    logic [2:0]        load_kind;
    logic              walk_begin, walk_begin_route;
    logic              walk_fin, walk_ok;
    logic [CNT_W-1:0]  depth_dec;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign dir = top_reg.head + top_reg.tried[1:0];
    assign nr  = {{(POS_W-ROW_W){1'b0}}, top_reg.r} + step_row(dir);
    assign nc  = {{(POS_W-COL_W){1'b0}}, top_reg.c} + step_col(dir);
    assign in_bounds = !nr[POS_W-1] && !nc[POS_W-1]
                    && (nr < {1'b0, used_rows}) && (nc < {1'b0, used_cols});
    assign depth_dec = depth_reg - CNT_W'(1);

    assign can_enter = (grid_rdata != K_WALL) && (grid_rdata != K_GOAL)
                    && (route_reg ? (grid_rdata != K_ROUTE && grid_rdata != K_DEAD)
                                  : (grid_rdata != K_SEEN));

    assign load_kind = (cell_kind == KIND_UNUSED) ? K_FREE : {1'b0, cell_kind};

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pend_next        = pend_reg;
        pend_addr_next   = pend_addr_reg;
        depth_next       = depth_reg;
        top_next         = top_reg;
        nb_r_next        = nb_r_reg;
        nb_c_next        = nb_c_reg;
        nb_head_next     = nb_head_reg;
        route_next       = route_reg;
        found_next       = found_reg;
        idx_next         = idx_reg;
        out_valid_next   = 1'b0;
        out_exp_next     = out_exp_reg;
        out_fin_next     = out_fin_reg;
        grid_we          = 1'b0;
        grid_waddr       = '0;
        grid_wdata       = K_FREE;
        grid_raddr       = {row, col};
        snap_we          = 1'b0;
        snap_waddr       = '0;
        snap_wdata       = K_FREE;
        snap_raddr       = {row, col};
        stk_we           = 1'b0;
        stk_waddr        = depth_dec[ADDR_W-1:0];
        stk_wdata        = top_reg;
        stk_raddr        = '0;
        walk_begin       = 1'b0;
        walk_begin_route = 1'b0;
        walk_fin         = 1'b0;
        walk_ok          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next = {row, col};
                    case (cmd)
                        CMD_LOAD:
                        begin
                            grid_we        = 1'b1;
                            grid_waddr     = {row, col};
                            grid_wdata     = load_kind;
                            snap_we        = 1'b1;
                            snap_waddr     = {row, col};
                            snap_wdata     = load_kind;
                            out_valid_next = 1'b1;
                            out_exp_next   = load_kind[1:0];
                            out_fin_next   = load_kind;
                        end
                        CMD_SEARCH:
                        begin
                            cnt_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_RD;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                out_valid_next = 1'b1;
                out_exp_next   = snap_rdata[1:0];
                out_fin_next   = grid_rdata;
                state_next     = S_IDLE;
            end
            S_CLR:
            begin
                // read one cell a cycle; in the next cycle, clear it to free if it holds a walk mark
                if (pend_reg && grid_rdata >= K_SEEN)
                begin
                    grid_we    = 1'b1;
                    grid_waddr = pend_addr_reg;
                    grid_wdata = K_FREE;
                end
                if (cnt_reg < CNT_W'(CELL_COUNT))
                begin
                    grid_raddr     = cnt_reg[ADDR_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_reg[ADDR_W-1:0];
                    cnt_next       = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        walk_begin = 1'b1;
                    end
                end
            end
            S_WALK:
            begin
                if (depth_reg == '0)
                begin
                    walk_fin = 1'b1;
                end
                else if (top_reg.tried == 3'd4)
                begin
                    if (route_reg)
                    begin
                        grid_we    = 1'b1;
                        grid_waddr = {top_reg.r, top_reg.c};
                        grid_wdata = K_DEAD;
                    end
                    depth_next = depth_dec;
                    stk_raddr  = ADDR_W'(depth_reg - CNT_W'(2));
                    if (depth_dec == '0)
                    begin
                        walk_fin = 1'b1;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
                else
                begin
                    top_next.tried = top_reg.tried + 3'd1;
                    if (in_bounds)
                    begin
                        grid_raddr   = {nr[ROW_W-1:0], nc[COL_W-1:0]};
                        nb_r_next    = nr[ROW_W-1:0];
                        nb_c_next    = nc[COL_W-1:0];
                        nb_head_next = route_reg ? 2'd0 : dir;
                        state_next   = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                state_next = S_WALK;
                if (grid_rdata == K_GOAL)
                begin
                    walk_fin = 1'b1;
                    walk_ok  = 1'b1;
                end
                else if (can_enter)
                begin
                    grid_we    = 1'b1;
                    grid_waddr = {nb_r_reg, nb_c_reg};
                    grid_wdata = route_reg ? K_ROUTE : K_SEEN;
                    stk_we     = (depth_reg != '0);
                    top_next   = '{r: nb_r_reg, c: nb_c_reg, head: nb_head_reg,
                                   tried: 3'd0};
                    depth_next = depth_reg + CNT_W'(1);
                end
            end
            S_POP:
            begin
                top_next   = stk_rdata;
                state_next = S_WALK;
            end
            S_COPY:
            begin
                if (pend_reg)
                begin
                    snap_we    = 1'b1;
                    snap_waddr = pend_addr_reg;
                    snap_wdata = grid_rdata;
                end
                if (cnt_reg < CNT_W'(CELL_COUNT))
                begin
                    grid_raddr     = cnt_reg[ADDR_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_reg[ADDR_W-1:0];
                    cnt_next       = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (found_reg)
                        begin
                            walk_begin       = 1'b1;
                            walk_begin_route = 1'b1;
                        end
                        else
                        begin
                            grid_raddr = idx_reg;
                            snap_raddr = idx_reg;
                            state_next = S_RD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (walk_begin)
        begin
            route_next   = walk_begin_route;
            depth_next   = '0;
            nb_r_next    = '0;
            nb_c_next    = '0;
            nb_head_next = 2'd0;
            if (used_rows != '0 && used_cols != '0)
            begin
                grid_raddr = '0;
                state_next = S_CHK;
            end
            else
            begin
                walk_fin = 1'b1;
            end
        end

        if (walk_fin)
        begin
            depth_next = '0;
            if (!route_next)
            begin
                found_next = walk_ok;
                cnt_next   = '0;
                pend_next  = 1'b0;
                state_next = S_COPY;
            end
            else
            begin
                grid_raddr = idx_reg;
                snap_raddr = idx_reg;
                state_next = S_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            depth_reg     <= '0;
            route_reg     <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            depth_reg     <= depth_next;
            route_reg     <= route_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        top_reg       <= top_next;
        nb_r_reg      <= nb_r_next;
        nb_c_reg      <= nb_c_next;
        nb_head_reg   <= nb_head_next;
        idx_reg       <= idx_next;
        out_exp_reg   <= out_exp_next;
        out_fin_reg   <= out_fin_next;
    end

    assign done         = out_valid_reg;
    assign goal_found   = found_reg;
    assign explore_mark = out_exp_reg;
    assign final_mark   = out_fin_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CNT_W'(CELL_COUNT))
        else $error("walk depth beyond cell count");

    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        stk_we |-> (state_reg == S_CHK) && (depth_reg != '0))
        else $error("frame saved with empty walk");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $past(state_reg == S_RD || (accept && cmd == CMD_LOAD)))
        else $error("result without a finished item");

    a_busy_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR || state_reg == S_COPY) |=> !out_valid_reg)
        else $error("result during a sweep");

endmodule
`default_nettype wire

>>> rtl/core/grid_maze_dfs_path_finder.sv
`default_nettype none
// Grid maze path finder. Commands are taken on start while busy is low:
// load a cell (free/wall/goal), run a search, or read a cell's marks. Every
// command gives exactly one result, shown for one cycle with done high; the
// receiver cannot stall it, so it must take done whenever it rises.
// Load: result the cycle after the transfer, busy stays low (one per cycle).
// Read: busy while the registered memory read is done, result right after.
// Search: a clear sweep over all 4096 cells, a depth-first walk that tries
// each heading of a cell and backtracks over the used grid, a copy sweep
// into the snapshot and, when a goal was reached, a second route walk; the
// marks and walk frames live in grid, snapshot and stack memories, each
// with one write port and one registered read port. grid_rows/grid_cols
// are written through the cfg channel (always ready); the user must write
// them only while the block is idle, and the block itself has no check for
// this. Values above 64 act as 64, zero makes the search fail at once.
module grid_maze_dfs_path_finder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  cmd,
    input  wire logic [gdfs_pkg::ROW_W-1:0]  row,
    input  wire logic [gdfs_pkg::COL_W-1:0]  col,
    input  wire logic [1:0]                  cell_kind,
    output logic                             done,
    output logic                             goal_found,
    output logic [1:0]                       explore_mark,
    output logic [2:0]                       final_mark,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [gdfs_pkg::DIM_W-1:0]  cfg_data
);
    import gdfs_pkg::*;

    logic [DIM_W-1:0]  grid_rows_reg, grid_cols_reg;
    logic [DIM_W-1:0]  used_rows, used_cols;

    logic              grid_we, snap_we, stk_we;
    logic [ADDR_W-1:0] grid_waddr, grid_raddr, snap_waddr, snap_raddr;
    logic [ADDR_W-1:0] stk_waddr, stk_raddr;
    logic [2:0]        grid_wdata, grid_rdata, snap_wdata, snap_rdata;
    frame_t            stk_wdata, stk_rdata;

    // config transfer: always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= DIM_W'(16);
            grid_cols_reg <= DIM_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_ROWS)
            begin
                grid_rows_reg <= cfg_data;
            end
            else if (cfg_index == REG_COLS)
            begin
                grid_cols_reg <= cfg_data;
            end
        end
    end

    // saturate to storage size
    assign used_rows = (grid_rows_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_rows_reg;
    assign used_cols = (grid_cols_reg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_cols_reg;

    gdfs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .row          (row),
        .col          (col),
        .cell_kind    (cell_kind),
        .used_rows    (used_rows),
        .used_cols    (used_cols),
        .grid_we      (grid_we),
        .grid_waddr   (grid_waddr),
        .grid_wdata   (grid_wdata),
        .grid_raddr   (grid_raddr),
        .grid_rdata   (grid_rdata),
        .snap_we      (snap_we),
        .snap_waddr   (snap_waddr),
        .snap_wdata   (snap_wdata),
        .snap_raddr   (snap_raddr),
        .snap_rdata   (snap_rdata),
        .stk_we       (stk_we),
        .stk_waddr    (stk_waddr),
        .stk_wdata    (stk_wdata),
        .stk_raddr    (stk_raddr),
        .stk_rdata    (stk_rdata),
        .done         (done),
        .goal_found   (goal_found),
        .explore_mark (explore_mark),
        .final_mark   (final_mark)
    );

    // live cell marks
    gdfs_ram #(.WIDTH(3), .DEPTH(CELL_COUNT)) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    // marks as left by the first walk (loads write here too)
    gdfs_ram #(.WIDTH(3), .DEPTH(CELL_COUNT)) u_snap (
        .clk   (clk),
        .we    (snap_we),
        .waddr (snap_waddr),
        .wdata (snap_wdata),
        .raddr (snap_raddr),
        .rdata (snap_rdata)
    );

    // frames below the top of the walk (top frame is held in registers)
    gdfs_ram #(.WIDTH(FRAME_W), .DEPTH(CELL_COUNT)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import gdfs_pkg::*;

    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;
    localparam int IDLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS = 1150;

    // ------------------------------------------------------------------
    // clock, reset, block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [1:0]       cmd = CMD_LOAD;
    logic [ROW_W-1:0] row = '0;
    logic [COL_W-1:0] col = '0;
    logic [1:0]       cell_kind = '0;
    logic             cfg_valid = 1'b0;
    logic [1:0]       cfg_index = REG_ROWS;
    logic [DIM_W-1:0] cfg_data = '0;

    logic             busy;
    logic             done;
    logic             goal_found;
    logic [1:0]       explore_mark;
    logic [2:0]       final_mark;
    logic             cfg_ready;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    grid_maze_dfs_path_finder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .row          (row),
        .col          (col),
        .cell_kind    (cell_kind),
        .done         (done),
        .goal_found   (goal_found),
        .explore_mark (explore_mark),
        .final_mark   (final_mark),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor state: live grid, snapshot after the explore walk,
    // walk stack and dimension registers
    // ------------------------------------------------------------------
    typedef struct packed {
        logic       goal;
        logic [1:0] emark;
        logic [2:0] fmark;
    } cell_report_t;

    logic [2:0] maze_grid [CELL_COUNT];
    logic [2:0] maze_snap [CELL_COUNT];
    bit         loaded    [CELL_COUNT];
    int         loaded_list[$];
    int         frm_r [CELL_COUNT];
    int         frm_c [CELL_COUNT];
    int         frm_head [CELL_COUNT];
    int         frm_tried [CELL_COUNT];
    int         walk_depth;
    logic [DIM_W-1:0] dim_rows = 7'd16;
    logic [DIM_W-1:0] dim_cols = 7'd16;
    int         lim_rows, lim_cols;
    logic       last_found = 1'b0;

    const int step_dr[4] = '{0, 1, 0, -1};
    const int step_dc[4] = '{1, 0, -1, 0};

    cell_report_t pending_reports[$];

    int errors = 0;
    int transfers = 0;
    int reports_seen = 0;
    int searches = 0;
    int goals_hit = 0;
    int burst_left = 0;

    // 0: blocked, 1: marked and pushed, 2: goal
    function automatic int try_enter(int r, int c, int hd, bit route);
        int         idx;
        logic [2:0] k;
        if (r < 0 || c < 0 || r >= lim_rows || c >= lim_cols)
            return 0;
        idx = r * MAX_COLS + c;
        k = maze_grid[idx];
        if (k == K_GOAL)
            return 2;
        if (k == K_WALL)
            return 0;
        if (!route && k == K_SEEN)
            return 0;
        if (route && (k == K_ROUTE || k == K_DEAD))
            return 0;
        if (walk_depth >= CELL_COUNT)
            return 0;
        maze_grid[idx] = route ? K_ROUTE : K_SEEN;
        frm_r[walk_depth] = r;
        frm_c[walk_depth] = c;
        frm_head[walk_depth] = hd;
        frm_tried[walk_depth] = 0;
        walk_depth++;
        return 1;
    endfunction

    function automatic bit dfs_walk(bit route);
        int res, d, t;
        walk_depth = 0;
        res = try_enter(0, 0, 0, route);
        if (res == 2)
            return 1;
        while (walk_depth > 0)
        begin
            t = walk_depth - 1;
            if (frm_tried[t] >= 4)
            begin
                // every heading failed: route walk leaves a dead end behind
                if (route)
                    maze_grid[frm_r[t] * MAX_COLS + frm_c[t]] = K_DEAD;
                walk_depth--;
                continue;
            end
            d = (frm_head[t] + frm_tried[t]) & 3;
            frm_tried[t]++;
            res = try_enter(frm_r[t] + step_dr[d], frm_c[t] + step_dc[d],
                            route ? 0 : d, route);
            if (res == 2)
            begin
                walk_depth = 0;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic void predict_search();
        bit hit;
        for (int i = 0; i < CELL_COUNT; i++)
            if (maze_grid[i] >= K_SEEN)
                maze_grid[i] = K_FREE;
        lim_rows = (dim_rows > MAX_ROWS) ? MAX_ROWS : int'(dim_rows);
        lim_cols = (dim_cols > MAX_COLS) ? MAX_COLS : int'(dim_cols);
        hit = dfs_walk(0);
        maze_snap = maze_grid;
        if (hit)
            void'(dfs_walk(1));
        last_found = hit;
        searches++;
        if (hit)
            goals_hit++;
    endfunction

    function automatic void predict_item(logic [1:0] c_cmd, int r, int c,
                                         logic [1:0] kind);
        int           idx;
        cell_report_t rep;
        idx = r * MAX_COLS + c;
        if (c_cmd == CMD_LOAD)
        begin
            maze_grid[idx] = (kind == KIND_UNUSED) ? K_FREE : {1'b0, kind};
            maze_snap[idx] = maze_grid[idx];
            if (!loaded[idx])
                loaded_list.push_back(idx);
            loaded[idx] = 1'b1;
        end
        else if (c_cmd == CMD_SEARCH)
            predict_search();
        rep.goal = last_found;
        rep.emark = maze_snap[idx][1:0];
        rep.fmark = maze_grid[idx];
        pending_reports.push_back(rep);
    endfunction

    // ------------------------------------------------------------------
    // result checker: done and the marks are registered, so they are
    // sampled mid-cycle
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        cell_report_t exp_rep;
        if (rst_n && done)
        begin
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected result goal=%0d emark=%0d fmark=%0d",
                         $time, goal_found, explore_mark, final_mark);
                errors++;
            end
            else
            begin
                exp_rep = pending_reports.pop_front();
                if (goal_found !== exp_rep.goal)
                begin
                    $display("%0t: goal_found expected %0d actual %0d",
                             $time, exp_rep.goal, goal_found);
                    errors++;
                end
                if (explore_mark !== exp_rep.emark)
                begin
                    $display("%0t: explore_mark expected %0d actual %0d",
                             $time, exp_rep.emark, explore_mark);
                    errors++;
                end
                if (final_mark !== exp_rep.fmark)
                begin
                    $display("%0t: final_mark expected %0d actual %0d",
                             $time, exp_rep.fmark, final_mark);
                    errors++;
                end
            end
        end
    end

    // watchdog: counts cycles with no transfer and no result
    int idle_cycles = 0;
    int seen_activity = 0;
    always @(posedge clk)
    begin
        if (transfers + reports_seen != seen_activity)
        begin
            seen_activity = transfers + reports_seen;
            idle_cycles = 0;
        end
        else if (rst_n)
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, %0d results outstanding",
                         $time, pending_reports.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // one command transfer; the sender runs in bursts with random gaps
    // ------------------------------------------------------------------
    task automatic send_item(logic [1:0] c_cmd, int r, int c, logic [1:0] kind);
        int  gap;
        bit  was_busy;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start <= 1'b1;
        cmd <= c_cmd;
        row <= r[ROW_W-1:0];
        col <= c[COL_W-1:0];
        cell_kind <= kind;
        forever
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
            if (!was_busy)
                break;
        end
        transfers++;
        predict_item(c_cmd, r, c, kind);
    endtask

    // register write, only once the block has drained
    task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
        bit rdy;
        start <= 1'b0;
        wait (pending_reports.size() == 0);
        repeat (16) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
            if (rdy)
                break;
        end
        cfg_valid <= 1'b0;
        if (idx == REG_ROWS)
            dim_rows = val;
        else if (idx == REG_COLS)
            dim_cols = val;
    endtask

    function automatic int eff_dim(logic [DIM_W-1:0] v, int cap);
        return (v > cap) ? cap : int'(v);
    endfunction

    task automatic read_loaded(int n);
        int idx;
        logic [1:0] rc;
        repeat (n)
        begin
            idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            rc = ($urandom_range(0, 7) == 0) ? CMD_SPARE : CMD_READ;
            send_item(rc, idx / MAX_COLS, idx % MAX_COLS, 2'($urandom));
        end
    endtask

    // fills the used area; wall_pct walls, one goal somewhere unless no_goal
    task automatic load_maze(int wall_pct, bit no_goal);
        int nr, nc, goal_at;
        logic [1:0] k;
        nr = eff_dim(dim_rows, MAX_ROWS);
        nc = eff_dim(dim_cols, MAX_COLS);
        goal_at = no_goal ? -1 : $urandom_range(0, nr * nc - 1);
        for (int i = 0; i < nr * nc; i++)
        begin
            if (i == goal_at)
                k = K_GOAL[1:0];
            else if ($urandom_range(0, 99) < wall_pct && i != 0)
                k = K_WALL[1:0];
            else
                k = ($urandom_range(0, 9) == 0) ? KIND_UNUSED : K_FREE[1:0];
            send_item(CMD_LOAD, i / nc, i % nc, k);
        end
    endtask

    task automatic run_maze(int wall_pct, bit no_goal, int n_reads);
        int idx;
        load_maze(wall_pct, no_goal);
        // the search reports on a cell that has been loaded
        idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        send_item(CMD_SEARCH, idx / MAX_COLS, idx % MAX_COLS, 2'($urandom));
        read_loaded(n_reads);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_default_size();
        // dimensions straight out of reset: 16 x 16
        run_maze(25, 0, 6);
    endtask

    task automatic test_far_corner();
        // last cell of the store, every kind including the unused one
        for (int k = 0; k < 4; k++)
        begin
            send_item(CMD_LOAD, MAX_ROWS - 1, MAX_COLS - 1, 2'(k));
            send_item(CMD_READ, MAX_ROWS - 1, MAX_COLS - 1, 2'(3 - k));
        end
        send_item(CMD_SPARE, MAX_ROWS - 1, MAX_COLS - 1, KIND_UNUSED);
    endtask

    task automatic test_start_is_goal();
        write_reg(REG_ROWS, 7'd2);
        write_reg(REG_COLS, 7'd2);
        send_item(CMD_LOAD, 0, 0, K_GOAL[1:0]);
        send_item(CMD_LOAD, 0, 1, K_FREE[1:0]);
        send_item(CMD_LOAD, 1, 0, K_WALL[1:0]);
        send_item(CMD_LOAD, 1, 1, K_FREE[1:0]);
        send_item(CMD_SEARCH, 0, 1, K_FREE[1:0]);
        read_loaded(3);
    endtask

    task automatic test_no_goal_and_rerun();
        write_reg(REG_ROWS, 7'd3);
        write_reg(REG_COLS, 7'd3);
        run_maze(20, 1, 3);
        // stale marks are cleared, second search matches the first
        send_item(CMD_SEARCH, 1, 1, K_FREE[1:0]);
        read_loaded(2);
    endtask

    task automatic test_empty_grid();
        write_reg(REG_ROWS, 7'd0);
        send_item(CMD_SEARCH, 0, 0, K_FREE[1:0]);
        read_loaded(2);
        write_reg(REG_ROWS, 7'd3);
        write_reg(REG_COLS, 7'd0);
        send_item(CMD_SEARCH, 0, 0, K_FREE[1:0]);
        read_loaded(1);
    endtask

    task automatic test_saturated_dims();
        // all-ones values act as the store bounds; keep the other side at 1
        write_reg(REG_ROWS, 7'd127);
        write_reg(REG_COLS, 7'd1);
        run_maze(5, 0, 3);
        write_reg(REG_ROWS, 7'd1);
        write_reg(REG_COLS, 7'd127);
        run_maze(5, 0, 3);
    endtask

    task automatic test_ignored_index();
        write_reg(REG_SPARE_A, 7'd127);
        write_reg(REG_SPARE_B, 7'd0);
        send_item(CMD_SEARCH, 0, 0, K_FREE[1:0]);
        read_loaded(2);
    endtask

    task automatic test_random_mazes();
        int base;
        base = transfers;
        while (transfers - base < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                write_reg(REG_ROWS, 7'($urandom_range(1, 20)));
                write_reg(REG_COLS, 7'($urandom_range(1, 20)));
            end
            else
            begin
                write_reg(REG_ROWS, 7'($urandom_range(1, 8)));
                write_reg(REG_COLS, 7'($urandom_range(1, 8)));
            end
            run_maze($urandom_range(0, 45), $urandom_range(0, 7) == 0,
                     $urandom_range(2, 10));
            // some noise: rewrite a few loaded cells and search again
            if ($urandom_range(0, 2) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    int idx;
                    idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                    send_item(CMD_LOAD, idx / MAX_COLS, idx % MAX_COLS,
                              2'($urandom));
                end
                send_item(CMD_SEARCH, 0, 0, K_FREE[1:0]);
                read_loaded($urandom_range(1, 5));
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_size();
        test_far_corner();
        test_start_is_goal();
        test_no_goal_and_rerun();
        test_empty_grid();
        test_saturated_dims();
        test_ignored_index();
        test_random_mazes();

        start <= 1'b0;
        wait (pending_reports.size() == 0);
        repeat (20) @(posedge clk);

        $display("Covered %0d command transfers, %0d searches (%0d reached a goal),",
                 transfers, searches, goals_hit);
        $display("grid sizes from empty to store bounds, with %0d results checked.",
                 reports_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/gdfs_pkg.sv
rtl/core/gdfs_ram.sv
rtl/core/gdfs_ctrl.sv
rtl/core/grid_maze_dfs_path_finder.sv
bench/testbench.sv
